>>> rtl/rsmf_pkg.sv
// shared types and constants for the repeat seed match filter
package rsmf_pkg;

  localparam int MAX_OCC = 20;

  typedef struct packed {
    logic [30:0] match_context;
    logic [31:0] query_offset;
    logic [31:0] subject_offset;
    logic        last_match;
  } match_t;

  typedef struct packed {
    logic        kind;
    logic [30:0] out_context;
    logic [31:0] out_query_offset;
    logic [31:0] out_subject_offset;
    logic [31:0] strand_max_count;
    logic [31:0] kept_count;
    logic        passes;
    logic        final_result;
  } result_t;

  typedef struct packed {
    logic [30:0] ctx;
    logic [31:0] qoff;
    logic [31:0] soff;
  } entry_t;

  typedef enum logic [1:0] {
    OP_INC,
    OP_ADD,
    OP_MAX,
    OP_GE
  } alu_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_FL_RD,
    ST_FL_EM,
    ST_SUM_MAX,
    ST_SUM_ADD,
    ST_SUM_GE,
    ST_SUM_EMIT
  } state_t;

  localparam logic KIND_MATCH   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

endpackage

>>> rtl/rsmf_store.sv
// group buffer memory with registered read
module rsmf_store #(
  parameter int DEPTH = 2 * rsmf_pkg::MAX_OCC
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  rsmf_pkg::entry_t         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output rsmf_pkg::entry_t         rdata
);

  rsmf_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/rsmf_alu.sv
// shared saturating add, max and compare unit
module rsmf_alu (
  input  rsmf_pkg::alu_op_t op,
  input  logic [31:0]       a,
  input  logic [31:0]       b,
  output logic [31:0]       y
);

  logic [32:0] sum;
  logic [32:0] diff;
  logic        ge;

  always_comb begin
    sum  = {1'b0, a} + ((op == rsmf_pkg::OP_INC) ? 33'd1 : {1'b0, b});
    diff = {1'b0, a} - {1'b0, b};
    ge   = ~diff[32];
    case (op)
      rsmf_pkg::OP_INC,
      rsmf_pkg::OP_ADD: y = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      rsmf_pkg::OP_MAX: y = ge ? a : b;
      rsmf_pkg::OP_GE:  y = {31'd0, ge};
      default:          y = 32'd0;
    endcase
  end

endmodule

>>> rtl/repeat_seed_match_filter.sv
// top level: repeat seed match filter with group buffer and sequencer
//
// Seed match words arrive on match (valid/ready), sorted by subject offset.
// Matches with one subject offset form a group; a strand with more than
// MAX_OCC matches in a group loses all of them. Kept match words and one
// summary word per list leave on result (valid/ready); final_result marks
// the last word caused by an input word. min_count is written through
// cfg_we/cfg_data; the user must write it only while the block is idle,
// which the block itself does not enforce. Words are taken one at a time.
// A word that neither closes a group nor ends the list passes through the
// add step. Closing a group of F buffered entries takes one memory read
// and one emit step per entry, and the end of a list adds another group
// close plus the summary steps (max, add, compare, emit), all sequenced
// through one saturating add/compare unit and the buffer's single read port.
// Reset clears the group and list state and sets min_count to 1.
// A stalled receiver holds the output register; the sequencer waits at its
// next emit step of a kept match or summary until the register frees.
module repeat_seed_match_filter #(
  parameter int MAX_OCC = rsmf_pkg::MAX_OCC
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              match_valid,
  output logic              match_ready,
  input  rsmf_pkg::match_t  match,
  output logic              result_valid,
  input  logic              result_ready,
  output rsmf_pkg::result_t result,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_data
);

  localparam int DEPTH = 2 * MAX_OCC;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int CW    = $clog2(MAX_OCC + 2);

  rsmf_pkg::state_t  state;
  rsmf_pkg::state_t  state_next;
  rsmf_pkg::match_t  item;
  rsmf_pkg::result_t out_next;
  rsmf_pkg::entry_t  rdata;
  rsmf_pkg::entry_t  wdata;
  rsmf_pkg::alu_op_t alu_op;

  logic          closing;
  logic          open;
  logic [31:0]   key;
  logic [FW-1:0] fill;
  logic [FW-1:0] k;
  logic [CW-1:0] counts   [2];
  logic          dropped  [2];
  logic [AW-1:0] last_idx [2];
  logic [31:0]   kept     [2];
  logic [31:0]   mx;
  logic [31:0]   total;
  logic          pass;
  logic [31:0]   min_count;

  logic          accept;
  logic          slot_free;
  logic          st;
  logic [CW-1:0] eff_cnt;
  logic          eff_drop;
  logic [CW-1:0] cnt_inc;
  logic          over;
  logic          mem_we;
  logic          est;
  logic          keep;
  logic [AW-1:0] final_idx;
  logic          load;
  logic [31:0]   alu_a;
  logic [31:0]   alu_b;
  logic [31:0]   alu_y;

  assign match_ready = (state == rsmf_pkg::ST_IDLE);
  assign accept      = match_valid & match_ready;
  assign slot_free   = ~result_valid | result_ready;

  assign st       = item.match_context[0];
  assign eff_cnt  = open ? counts[st] : '0;
  assign eff_drop = open ? dropped[st] : 1'b0;
  assign cnt_inc  = eff_cnt + CW'(1);
  assign over     = cnt_inc > CW'(MAX_OCC);
  assign est      = rdata.ctx[0];
  assign keep     = ~dropped[est];
  assign wdata    = '{ctx: item.match_context, qoff: item.query_offset,
                      soff: item.subject_offset};

  always_comb begin
    if (dropped[0]) begin
      final_idx = last_idx[1];
    end else if (dropped[1]) begin
      final_idx = last_idx[0];
    end else begin
      final_idx = (last_idx[0] > last_idx[1]) ? last_idx[0] : last_idx[1];
    end
  end

  rsmf_store #(
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .waddr(fill[AW-1:0]),
    .wdata(wdata),
    .re   (state == rsmf_pkg::ST_FL_RD),
    .raddr(k[AW-1:0]),
    .rdata(rdata)
  );

  rsmf_alu u_alu (
    .op(alu_op),
    .a (alu_a),
    .b (alu_b),
    .y (alu_y)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      rsmf_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (open && match.subject_offset != key) ?
                       rsmf_pkg::ST_FL_RD : rsmf_pkg::ST_ADD;
        end
      end
      rsmf_pkg::ST_ADD: begin
        state_next = item.last_match ? rsmf_pkg::ST_FL_RD : rsmf_pkg::ST_IDLE;
      end
      rsmf_pkg::ST_FL_RD: begin
        if (k == fill) begin
          state_next = closing ? rsmf_pkg::ST_SUM_MAX : rsmf_pkg::ST_ADD;
        end else begin
          state_next = rsmf_pkg::ST_FL_EM;
        end
      end
      rsmf_pkg::ST_FL_EM: begin
        if (~keep || slot_free) begin
          state_next = rsmf_pkg::ST_FL_RD;
        end
      end
      rsmf_pkg::ST_SUM_MAX: state_next = rsmf_pkg::ST_SUM_ADD;
      rsmf_pkg::ST_SUM_ADD: state_next = rsmf_pkg::ST_SUM_GE;
      rsmf_pkg::ST_SUM_GE:  state_next = rsmf_pkg::ST_SUM_EMIT;
      rsmf_pkg::ST_SUM_EMIT: begin
        if (slot_free) begin
          state_next = rsmf_pkg::ST_IDLE;
        end
      end
      default: state_next = rsmf_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    mem_we   = 1'b0;
    load     = 1'b0;
    alu_op   = rsmf_pkg::OP_INC;
    alu_a    = 32'd0;
    alu_b    = 32'd0;
    out_next = '0;
    case (state)
      rsmf_pkg::ST_ADD: begin
        mem_we = ~eff_drop & ~over;
      end
      rsmf_pkg::ST_FL_EM: begin
        alu_op = rsmf_pkg::OP_INC;
        alu_a  = kept[est];
        load   = keep & slot_free;
        out_next.kind               = rsmf_pkg::KIND_MATCH;
        out_next.out_context        = rdata.ctx;
        out_next.out_query_offset   = rdata.qoff;
        out_next.out_subject_offset = rdata.soff;
        out_next.final_result       = ~closing && ~item.last_match &&
                                      (k[AW-1:0] == final_idx);
      end
      rsmf_pkg::ST_SUM_MAX: begin
        alu_op = rsmf_pkg::OP_MAX;
        alu_a  = kept[0];
        alu_b  = kept[1];
      end
      rsmf_pkg::ST_SUM_ADD: begin
        alu_op = rsmf_pkg::OP_ADD;
        alu_a  = kept[0];
        alu_b  = kept[1];
      end
      rsmf_pkg::ST_SUM_GE: begin
        alu_op = rsmf_pkg::OP_GE;
        alu_a  = mx;
        alu_b  = min_count;
      end
      rsmf_pkg::ST_SUM_EMIT: begin
        load = slot_free;
        out_next.kind             = rsmf_pkg::KIND_SUMMARY;
        out_next.strand_max_count = mx;
        out_next.kept_count       = total;
        out_next.passes           = pass;
        out_next.final_result     = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rsmf_pkg::ST_IDLE;
      closing      <= 1'b0;
      open         <= 1'b0;
      key          <= 32'd0;
      fill         <= '0;
      k            <= '0;
      counts[0]    <= '0;
      counts[1]    <= '0;
      dropped[0]   <= 1'b0;
      dropped[1]   <= 1'b0;
      last_idx[0]  <= '0;
      last_idx[1]  <= '0;
      kept[0]      <= 32'd0;
      kept[1]      <= 32'd0;
      min_count    <= 32'd1;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        min_count <= cfg_data;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        rsmf_pkg::ST_IDLE: begin
          if (accept) begin
            closing <= 1'b0;
            k       <= '0;
          end
        end
        rsmf_pkg::ST_ADD: begin
          if (!open) begin
            open          <= 1'b1;
            key           <= item.subject_offset;
            counts[~st]   <= '0;
            dropped[~st]  <= 1'b0;
            last_idx[~st] <= '0;
            dropped[st]   <= 1'b0;
          end
          if (!eff_drop) begin
            if (over) begin
              dropped[st] <= 1'b1;
            end else begin
              counts[st]   <= cnt_inc;
              last_idx[st] <= fill[AW-1:0];
              fill         <= fill + FW'(1);
            end
          end
          closing <= item.last_match;
          k       <= '0;
        end
        rsmf_pkg::ST_FL_RD: begin
          if (k == fill) begin
            fill <= '0;
            open <= 1'b0;
          end
        end
        rsmf_pkg::ST_FL_EM: begin
          if (~keep || slot_free) begin
            k <= k + FW'(1);
          end
          if (keep && slot_free) begin
            kept[est] <= alu_y;
          end
        end
        rsmf_pkg::ST_SUM_MAX: mx    <= alu_y;
        rsmf_pkg::ST_SUM_ADD: total <= alu_y;
        rsmf_pkg::ST_SUM_GE:  pass  <= alu_y[0];
        rsmf_pkg::ST_SUM_EMIT: begin
          if (slot_free) begin
            kept[0]    <= 32'd0;
            kept[1]    <= 32'd0;
            key        <= 32'd0;
            counts[0]  <= '0;
            counts[1]  <= '0;
            dropped[0] <= 1'b0;
            dropped[1] <= 1'b0;
          end
        end
        default: begin
          k <= k;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= match;
    end
    if (load) begin
      result <= out_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= FW'(DEPTH))
    else $error("group buffer fill beyond depth");

  assert property (@(posedge clk) disable iff (rst)
    state == rsmf_pkg::ST_FL_EM |-> k < fill)
    else $error("emit step past buffer fill");

  assert property (@(posedge clk) disable iff (rst)
    (open && !dropped[0]) |-> counts[0] <= CW'(MAX_OCC))
    else $error("forward strand count over limit while kept");

  assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.kind == rsmf_pkg::KIND_SUMMARY) |-> result.final_result)
    else $error("summary word without final mark");

  assert property (@(posedge clk) disable iff (rst)
    (state == rsmf_pkg::ST_ADD) |=> (open || item.last_match))
    else $error("group not open after adding a match");

endmodule
